### sv/srlt_pkg.sv
// srlt_pkg: shared constants, types and helpers for the source rate lockout table
// used by the word interfaces and the top level; no dependencies

package srlt_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam int ADDR_W  = 64;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 8;
    localparam int WIN_W   = 31;
    localparam int HIGH_W  = 8;
    localparam int LOW_W   = 7;
    localparam int COUNT_W = 8;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER  = 2'd3;

    localparam logic [LIMIT_W-1:0] HIT_LIMIT_RST  = 8'd5;
    localparam logic [WIN_W-1:0]   WINDOW_RST     = 31'd3600;
    localparam logic [HIGH_W-1:0]  HIGH_WATER_RST = 8'd116;
    localparam logic [LOW_W-1:0]   LOW_WATER_RST  = 7'd100;

    localparam logic [ADDR_W-1:0] LOOP_V4    = 64'h0000_0000_7F00_0001;
    localparam logic [ADDR_W-1:0] LOOP_V6_LO = 64'h0000_0000_0000_0001;
    localparam logic [ADDR_W-1:0] V4_MASK    = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic              family;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [TIME_W-1:0] etime;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_TRIM   = 6'b000100,
        S_LOAD   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    // ring index plus offset, offset at most the depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum >= SUM_W'(HISTORY_DEPTH)) begin
            sum = sum - SUM_W'(HISTORY_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### sv/srlt_evt_if.sv
// srlt_evt_if: valid/ready channel carrying one failed-login event word
// depends on srlt_pkg

interface srlt_evt_if;
    logic                        valid;
    logic                        ready;
    logic                        addr_is_v6;
    logic [srlt_pkg::ADDR_W-1:0] addr_hi;
    logic [srlt_pkg::ADDR_W-1:0] addr_lo;
    logic [srlt_pkg::TIME_W-1:0] event_time;

    modport source (output valid, output addr_is_v6, output addr_hi, output addr_lo,
                    output event_time, input ready);
    modport sink   (input valid, input addr_is_v6, input addr_hi, input addr_lo,
                    input event_time, output ready);
endinterface

### sv/srlt_res_if.sv
// srlt_res_if: valid/ready channel carrying one verdict word
// depends on srlt_pkg

interface srlt_res_if;
    logic                         valid;
    logic                         ready;
    logic                         ignored;
    logic                         block_source;
    logic [srlt_pkg::COUNT_W-1:0] match_count;

    modport source (output valid, output ignored, output block_source,
                    output match_count, input ready);
    modport sink   (input valid, input ignored, input block_source,
                    input match_count, output ready);
endinterface

### sv/source_rate_lockout_table.sv
// source_rate_lockout_table: sliding-window failed-login limiter over a ring history
// depends on srlt_pkg, srlt_evt_if, srlt_res_if
//
// Each event word is appended to a ring history (loopback sources are answered at
// once with ignored set and nothing stored), the history is trimmed to the low water
// mark once it passes both the high and the low water mark, and the history is then
// scanned one entry per cycle through the single read port of the history memory,
// counting entries of the same source that are younger than the window. After the
// event is taken it passes the append, trim and load states, the scan over the held
// entries (after trimming) and the output state, which loads the verdict; a loopback
// source goes from idle straight to the output state. The input is not ready while
// an event is in work and is ready again once the verdict is loaded. A finished
// verdict waits in the output register while the next event is taken; one that
// finishes while the register still holds an untaken word waits until it is taken.

module source_rate_lockout_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srlt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srlt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    srlt_evt_if.sink                         i_evt,
    srlt_res_if.source                       o_res
);

    // configuration
    logic [srlt_pkg::LIMIT_W-1:0] r_hit_limit;
    logic [srlt_pkg::WIN_W-1:0]   r_window;
    logic [srlt_pkg::HIGH_W-1:0]  r_high_water;
    logic [srlt_pkg::LOW_W-1:0]   r_low_water;

    // control
    srlt_pkg::t_state r_state, n_state;
    logic [srlt_pkg::IDX_W-1:0] r_head, n_head;
    logic [srlt_pkg::CNT_W-1:0] r_count, n_count;
    logic [srlt_pkg::IDX_W-1:0] r_ptr, n_ptr;
    logic [srlt_pkg::CNT_W-1:0] r_left, n_left;
    logic                       r_rd_vld, n_rd_vld;
    logic [7:0]                 r_found, n_found;
    logic                       r_out_valid, n_out_valid;

    // payload
    srlt_pkg::t_entry r_key, n_key;
    srlt_pkg::t_entry r_rd_data;
    logic                         r_res_ignored, n_res_ignored;
    logic                         r_res_block, n_res_block;
    logic [srlt_pkg::COUNT_W-1:0] r_res_count, n_res_count;

    srlt_pkg::t_entry r_mem [srlt_pkg::HISTORY_DEPTH];

    logic                       w_wr_en;
    logic [srlt_pkg::IDX_W-1:0] w_wr_slot;
    logic                       w_accept;
    logic                       w_loop;
    logic [srlt_pkg::ADDR_W-1:0] w_in_hi, w_in_lo;
    logic                       w_full;
    logic [srlt_pkg::IDX_W-1:0] w_head0;
    logic [srlt_pkg::CNT_W-1:0] w_count0;
    logic [srlt_pkg::CMP_W-1:0] w_cnt_cmp;
    logic                       w_trim;
    logic [srlt_pkg::CNT_W-1:0] w_drop;
    logic                       w_addr_eq;
    logic [srlt_pkg::TIME_W-1:0] w_age;
    logic                       w_recent;
    logic [8:0]                 w_cap;

    assign i_evt.ready = (r_state == srlt_pkg::S_IDLE);
    assign w_accept    = i_evt.valid && i_evt.ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.ignored      = r_res_ignored;
    assign o_res.block_source = r_res_block;
    assign o_res.match_count  = r_res_count;

    // normalized source key
    always_comb begin
        if (i_evt.addr_is_v6) begin
            w_in_hi = i_evt.addr_hi;
            w_in_lo = i_evt.addr_lo;
            w_loop  = (i_evt.addr_hi == '0) && (i_evt.addr_lo == srlt_pkg::LOOP_V6_LO);
        end else begin
            w_in_hi = '0;
            w_in_lo = i_evt.addr_lo & srlt_pkg::V4_MASK;
            w_loop  = (w_in_lo == srlt_pkg::LOOP_V4);
        end
    end

    // append step: make room when full, then write at the tail
    assign w_full    = (r_count == srlt_pkg::CNT_W'(srlt_pkg::HISTORY_DEPTH));
    assign w_head0   = w_full ? srlt_pkg::wrap_add(r_head, srlt_pkg::CNT_W'(1)) : r_head;
    assign w_count0  = w_full ? (r_count - srlt_pkg::CNT_W'(1)) : r_count;
    assign w_wr_slot = srlt_pkg::wrap_add(w_head0, w_count0);
    assign w_wr_en   = (r_state == srlt_pkg::S_APPEND);

    // trim step
    assign w_cnt_cmp = srlt_pkg::CMP_W'(r_count);
    assign w_trim    = (w_cnt_cmp > srlt_pkg::CMP_W'(r_high_water)) &&
                       (w_cnt_cmp > srlt_pkg::CMP_W'(r_low_water));
    assign w_drop    = srlt_pkg::CNT_W'(w_cnt_cmp - srlt_pkg::CMP_W'(r_low_water));

    // scan compare on the registered read word
    assign w_addr_eq = (r_rd_data.family == r_key.family) &&
                       (r_rd_data.addr_hi == r_key.addr_hi) &&
                       (r_rd_data.addr_lo == r_key.addr_lo);
    assign w_age     = r_key.etime - r_rd_data.etime;
    assign w_recent  = w_age[srlt_pkg::TIME_W-1] ||
                       (w_age < {1'b0, r_window});
    assign w_cap     = (r_hit_limit == 8'hFF) ? 9'd255 : ({1'b0, r_hit_limit} + 9'd1);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_left        = r_left;
        n_rd_vld      = 1'b0;
        n_found       = r_found;
        n_key         = r_key;
        n_out_valid   = r_out_valid;
        n_res_ignored = r_res_ignored;
        n_res_block   = r_res_block;
        n_res_count   = r_res_count;

        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            srlt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key.family  = i_evt.addr_is_v6;
                    n_key.addr_hi = w_in_hi;
                    n_key.addr_lo = w_in_lo;
                    n_key.etime   = i_evt.event_time;
                    if (w_loop) begin
                        n_found = '0;
                        n_state = srlt_pkg::S_OUT;
                    end else begin
                        n_state = srlt_pkg::S_APPEND;
                    end
                end
            end
            srlt_pkg::S_APPEND: begin
                n_head  = w_head0;
                n_count = w_count0 + srlt_pkg::CNT_W'(1);
                n_state = srlt_pkg::S_TRIM;
            end
            srlt_pkg::S_TRIM: begin
                if (w_trim) begin
                    n_head  = srlt_pkg::wrap_add(r_head, w_drop);
                    n_count = srlt_pkg::CNT_W'(r_low_water);
                end
                n_state = srlt_pkg::S_LOAD;
            end
            srlt_pkg::S_LOAD: begin
                n_ptr   = r_head;
                n_left  = r_count;
                n_found = '0;
                n_state = srlt_pkg::S_SCAN;
            end
            srlt_pkg::S_SCAN: begin
                if (r_rd_vld && w_addr_eq && w_recent && ({1'b0, r_found} < w_cap)) begin
                    n_found = r_found + 8'd1;
                end
                if (r_left != '0) begin
                    n_ptr    = srlt_pkg::wrap_add(r_ptr, srlt_pkg::CNT_W'(1));
                    n_left   = r_left - srlt_pkg::CNT_W'(1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = srlt_pkg::S_OUT;
                end
            end
            srlt_pkg::S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid   = 1'b1;
                    n_res_ignored = (n_found == '0) &&
                                    (r_key.family ? ((r_key.addr_hi == '0) &&
                                     (r_key.addr_lo == srlt_pkg::LOOP_V6_LO))
                                    : (r_key.addr_lo == srlt_pkg::LOOP_V4));
                    n_res_block   = n_res_ignored ? 1'b0 : (r_found > r_hit_limit);
                    n_res_count   = n_res_ignored ? '0 : r_found;
                    n_state       = srlt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srlt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srlt_pkg::S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_ptr        <= '0;
            r_left       <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= '0;
            r_out_valid  <= 1'b0;
            r_hit_limit  <= srlt_pkg::HIT_LIMIT_RST;
            r_window     <= srlt_pkg::WINDOW_RST;
            r_high_water <= srlt_pkg::HIGH_WATER_RST;
            r_low_water  <= srlt_pkg::LOW_WATER_RST;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_left      <= n_left;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    srlt_pkg::REG_HIT_LIMIT:  r_hit_limit  <= i_cfg_data[srlt_pkg::LIMIT_W-1:0];
                    srlt_pkg::REG_WINDOW:     r_window     <= i_cfg_data[srlt_pkg::WIN_W-1:0];
                    srlt_pkg::REG_HIGH_WATER: r_high_water <= i_cfg_data[srlt_pkg::HIGH_W-1:0];
                    srlt_pkg::REG_LOW_WATER:  r_low_water  <= i_cfg_data[srlt_pkg::LOW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_res_ignored <= n_res_ignored;
        r_res_block   <= n_res_block;
        r_res_count   <= n_res_count;
    end

    // history memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_slot] <= r_key;
        end
        r_rd_data <= r_mem[r_ptr];
    end

endmodule

### tb/tb_source_rate_lockout_table.sv
// tb_source_rate_lockout_table: self-checking bench for the source rate lockout table
// needs srlt_pkg, srlt_evt_if, srlt_res_if and source_rate_lockout_table; random
// failed-login words are checked against an in-bench model of the ring history

module tb_source_rate_lockout_table;

    typedef struct packed {
        logic                        is_v6;
        logic [srlt_pkg::ADDR_W-1:0] hi;
        logic [srlt_pkg::ADDR_W-1:0] lo;
        logic [srlt_pkg::TIME_W-1:0] stamp;
    } t_login_word;

    typedef struct packed {
        logic                         ignored;
        logic                         block;
        logic [srlt_pkg::COUNT_W-1:0] count;
    } t_verdict;

    class t_lockout_tracker;
        logic [srlt_pkg::LIMIT_W-1:0] hit_limit;
        logic [srlt_pkg::WIN_W-1:0]   window;
        logic [srlt_pkg::HIGH_W-1:0]  high_water;
        logic [srlt_pkg::LOW_W-1:0]   low_water;
        logic                         h_fam   [srlt_pkg::HISTORY_DEPTH];
        logic [srlt_pkg::ADDR_W-1:0]  h_hi    [srlt_pkg::HISTORY_DEPTH];
        logic [srlt_pkg::ADDR_W-1:0]  h_lo    [srlt_pkg::HISTORY_DEPTH];
        logic [srlt_pkg::TIME_W-1:0]  h_stamp [srlt_pkg::HISTORY_DEPTH];
        int unsigned                  head;
        int unsigned                  held;
        t_verdict                     verdicts_due[$];
        int                           errors;

        function new();
            hit_limit  = srlt_pkg::HIT_LIMIT_RST;
            window     = srlt_pkg::WINDOW_RST;
            high_water = srlt_pkg::HIGH_WATER_RST;
            low_water  = srlt_pkg::LOW_WATER_RST;
            head       = 0;
            held       = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [srlt_pkg::CFG_IDX_W-1:0] idx,
                              logic [srlt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                srlt_pkg::REG_HIT_LIMIT:  hit_limit  = data[srlt_pkg::LIMIT_W-1:0];
                srlt_pkg::REG_WINDOW:     window     = data[srlt_pkg::WIN_W-1:0];
                srlt_pkg::REG_HIGH_WATER: high_water = data[srlt_pkg::HIGH_W-1:0];
                srlt_pkg::REG_LOW_WATER:  low_water  = data[srlt_pkg::LOW_W-1:0];
                default: ;
            endcase
        endfunction

        function void drop_oldest();
            if (held != 0) begin
                head = (head + 1) % srlt_pkg::HISTORY_DEPTH;
                held--;
            end
        endfunction

        function void note_event(t_login_word w);
            logic [srlt_pkg::ADDR_W-1:0] a_hi;
            logic [srlt_pkg::ADDR_W-1:0] a_lo;
            logic [srlt_pkg::TIME_W-1:0] age;
            logic                        loop;
            int unsigned                 slot;
            int unsigned                 s;
            int unsigned                 cap;
            int unsigned                 found;
            t_verdict                    v;
            a_hi = w.hi;
            a_lo = w.lo;
            v = '0;
            if (!w.is_v6) begin
                a_hi = '0;
                a_lo = a_lo & srlt_pkg::V4_MASK;
                loop = (a_lo == srlt_pkg::LOOP_V4);
            end else begin
                loop = (a_hi == '0) && (a_lo == srlt_pkg::LOOP_V6_LO);
            end
            if (loop) begin
                v.ignored = 1'b1;
                verdicts_due.push_back(v);
                return;
            end
            if (held >= srlt_pkg::HISTORY_DEPTH) drop_oldest();
            slot = (head + held) % srlt_pkg::HISTORY_DEPTH;
            h_fam[slot]   = w.is_v6;
            h_hi[slot]    = a_hi;
            h_lo[slot]    = a_lo;
            h_stamp[slot] = w.stamp;
            held++;
            if (held > high_water) begin
                while (held > low_water) drop_oldest();
            end
            cap = int'(hit_limit) + 1;
            if (cap > 255) cap = 255;
            found = 0;
            for (int k = 0; k < held && found < cap; k++) begin
                s = (head + k) % srlt_pkg::HISTORY_DEPTH;
                if (h_fam[s] == w.is_v6 && h_hi[s] == a_hi && h_lo[s] == a_lo) begin
                    age = w.stamp - h_stamp[s];
                    if (age[srlt_pkg::TIME_W-1] || age < srlt_pkg::TIME_W'(window)) found++;
                end
            end
            v.block = (found > hit_limit);
            v.count = found[srlt_pkg::COUNT_W-1:0];
            verdicts_due.push_back(v);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("verdict with none expected: ignored=%0d block=%0d count=%0d",
                             got.ignored, got.block, got.count);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.ignored !== want.ignored || got.block !== want.block ||
                got.count !== want.count) begin
                errors++;
                if (errors <= 10)
                    $display("verdict mismatch: expected ignored=%0d block=%0d count=%0d, %s",
                             want.ignored, want.block, want.count,
                             $sformatf("got ignored=%0d block=%0d count=%0d",
                                       got.ignored, got.block, got.count));
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [srlt_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [srlt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    srlt_evt_if evt_ch ();
    srlt_res_if res_ch ();

    source_rate_lockout_table dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_evt     (evt_ch),
        .o_res     (res_ch)
    );

    t_lockout_tracker board;
    int             idle_pct;
    int             stall_pct;
    int unsigned    tstep;
    logic [srlt_pkg::TIME_W-1:0] now;
    logic                        pool_v6 [8];
    logic [srlt_pkg::ADDR_W-1:0] pool_hi [8];
    logic [srlt_pkg::ADDR_W-1:0] pool_lo [8];
    int                          pool_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // verdict side: check accepted words, then roll ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                board.check_verdict({res_ch.ignored, res_ch.block_source, res_ch.match_count});
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic t_login_word mk(logic v6, logic [srlt_pkg::ADDR_W-1:0] hi,
                                       logic [srlt_pkg::ADDR_W-1:0] lo,
                                       logic [srlt_pkg::TIME_W-1:0] t);
        t_login_word w;
        w.is_v6 = v6;
        w.hi    = hi;
        w.lo    = lo;
        w.stamp = t;
        return w;
    endfunction

    function automatic logic [srlt_pkg::ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void fill_pool(int n);
        pool_n = n;
        for (int i = 0; i < n; i++) begin
            pool_v6[i] = 1'($urandom_range(0, 1));
            pool_hi[i] = pool_v6[i] ? rand64() : '0;
            pool_lo[i] = pool_v6[i] ? rand64() : {32'h0, $urandom};
        end
    endfunction

    function automatic t_login_word rand_event();
        t_login_word w;
        int          roll;
        int          pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 3);
        if (roll < 5) begin
            // loopback sources, v4 with junk in the unused bits
            if (pick[0]) w = mk(1'b1, '0, srlt_pkg::LOOP_V6_LO, '0);
            else w = mk(1'b0, rand64(), {$urandom, srlt_pkg::LOOP_V4[31:0]}, '0);
        end else if (roll < 9) begin
            // near misses of loopback
            case (pick)
                0: w = mk(1'b0, '0, srlt_pkg::LOOP_V4 + 1, '0);
                1: w = mk(1'b1, '0, '0, '0);
                2: w = mk(1'b1, 64'h1 << $urandom_range(0, 63), srlt_pkg::LOOP_V6_LO, '0);
                default: w = mk(1'b1, '0, srlt_pkg::LOOP_V4, '0);
            endcase
        end else if (roll < 19) begin
            w = mk(1'($urandom_range(0, 1)), rand64(), rand64(), '0);
        end else begin
            pick = $urandom_range(0, pool_n - 1);
            w = mk(pool_v6[pick], pool_hi[pick], pool_lo[pick], '0);
            if (!pool_v6[pick] && $urandom_range(0, 1)) begin
                w.hi = rand64();
                w.lo[63:32] = $urandom;
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            w.stamp = now - $urandom_range(0, tstep);
        end else if (roll < 9) begin
            w.stamp = $urandom;
        end else begin
            now = now + $urandom_range(0, tstep);
            w.stamp = now;
        end
        return w;
    endfunction

    task automatic send_event(input t_login_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            evt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.addr_is_v6 <= w.is_v6;
        evt_ch.addr_hi    <= w.hi;
        evt_ch.addr_lo    <= w.lo;
        evt_ch.event_time <= w.stamp;
        do @(posedge i_clk); while (!evt_ch.ready);
        board.note_event(w);
    endtask

    task automatic wait_idle();
        evt_ch.valid <= 1'b0;
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (srlt_pkg::HISTORY_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [srlt_pkg::LIMIT_W-1:0] lim,
                               input logic [srlt_pkg::WIN_W-1:0] win,
                               input logic [srlt_pkg::HIGH_W-1:0] hw,
                               input logic [srlt_pkg::LOW_W-1:0] lw);
        logic [srlt_pkg::CFG_DATA_W-1:0] vals [4];
        logic [srlt_pkg::CFG_IDX_W-1:0]  regs [4];
        vals = '{srlt_pkg::CFG_DATA_W'(lim), srlt_pkg::CFG_DATA_W'(win),
                 srlt_pkg::CFG_DATA_W'(hw), srlt_pkg::CFG_DATA_W'(lw)};
        regs = '{srlt_pkg::REG_HIT_LIMIT, srlt_pkg::REG_WINDOW,
                 srlt_pkg::REG_HIGH_WATER, srlt_pkg::REG_LOW_WATER};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            board.set_reg(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [srlt_pkg::LIMIT_W-1:0] lim,
                             input logic [srlt_pkg::WIN_W-1:0] win,
                             input logic [srlt_pkg::HIGH_W-1:0] hw,
                             input logic [srlt_pkg::LOW_W-1:0] lw,
                             input int idle, input int stall, input int n,
                             input int unsigned step, input int npool);
        wait_idle();
        load_limits(lim, win, hw, lw);
        idle_pct  = idle;
        stall_pct = stall;
        tstep     = step;
        fill_pool(npool);
        repeat (n) send_event(rand_event());
    endtask

    initial begin
        #20_000_000;
        $display("tb_source_rate_lockout_table failed");
        $finish;
    end

    initial begin
        board = new();
        idle_pct  = 0;
        stall_pct = 0;
        tstep     = 0;
        now       = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= srlt_pkg::REG_HIT_LIMIT;
        i_cfg_data        <= '0;
        evt_ch.valid      <= 1'b0;
        evt_ch.addr_is_v6 <= 1'b0;
        evt_ch.addr_hi    <= '0;
        evt_ch.addr_lo    <= '0;
        evt_ch.event_time <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // loopback forms and their near misses, field extremes
        send_event(mk(1'b0, '1, {32'hFFFF_FFFF, srlt_pkg::LOOP_V4[31:0]}, 32'd0));
        send_event(mk(1'b0, '0, srlt_pkg::LOOP_V4, 32'd1));
        send_event(mk(1'b1, '0, srlt_pkg::LOOP_V6_LO, 32'd2));
        send_event(mk(1'b1, '0, srlt_pkg::LOOP_V4, 32'd3));
        send_event(mk(1'b1, 64'h1, srlt_pkg::LOOP_V6_LO, 32'd4));
        send_event(mk(1'b1, '0, '0, 32'd5));
        send_event(mk(1'b0, '1, '1, 32'hFFFF_FFFF));
        send_event(mk(1'b1, '1, '1, 32'd0));
        send_event(mk(1'b0, '0, '0, 32'd0));
        // one source past the reset hit limit, junk in unused v4 bits
        for (int i = 0; i < 7; i++)
            send_event(mk(1'b0, i[0] ? '1 : '0, {i[0] ? 32'hDEAD_BEEF : 32'h0, 32'h0A00_0001},
                          32'd100 + i));
        // age exactly at the window, then an older word
        send_event(mk(1'b0, '0, 64'h0A00_0002, 32'd1000));
        send_event(mk(1'b0, '0, 64'h0A00_0002, 32'd4600));
        send_event(mk(1'b0, '0, 64'h0A00_0002, 32'd4599));
        // same low bits but other family
        send_event(mk(1'b1, '0, 64'h0A00_0001, 32'd106));
        // time wrap
        send_event(mk(1'b0, '0, 64'h0A00_0003, 32'hFFFF_FFF0));
        send_event(mk(1'b0, '0, 64'h0A00_0003, 32'h0000_0010));

        run_phase(8'd3,   31'd100,        8'd128, 7'd127, 0,  0,  260, 20,           4);
        run_phase(8'd0,   31'd1,          8'd2,   7'd1,   49, 0,  150, 1,            3);
        run_phase(8'd254, 31'h7FFF_FFFF,  8'd64,  7'd1,   0,  49, 200, 32'h4000_0000, 3);
        run_phase(8'd255, 31'd0,          8'd10,  7'd0,   22, 22, 120, 10,           3);
        now = 32'hFFFF_0000;
        run_phase(8'd5,   31'd3600,       8'd116, 7'd100, 22, 22, 300, 300,          5);
        run_phase(8'd7,   31'd50,         8'd20,  7'd40,  49, 0,  200, 5,            3);
        run_phase(8'd1,   31'd1000,       8'd64,  7'd32,  0,  49, 200, 100,          6);
        run_phase(8'd20,  31'd5000,       8'd255, 7'd127, 0,  0,  220, 60,           2);

        wait_idle();
        if (board.errors == 0 && board.verdicts_due.size() == 0) begin
            $display("tb_source_rate_lockout_table passed");
        end else begin
            $display("tb_source_rate_lockout_table failed");
        end
        $finish;
    end

endmodule
